### hdl/bft_pkg.sv
// ----------------------------------------------------------------------------
// bft_pkg
// Shared sizes, codes, item and result types for the bigram frequency table.
// ----------------------------------------------------------------------------
package bft_pkg;

  // Table dimensions and counter width
  localparam int PRIMARY_SLOTS   = 32;
  localparam int SUCCESSOR_SLOTS = 32;
  localparam int COUNT_BITS      = 16;

  // Derived index and count widths
  localparam int PI_W       = $clog2(PRIMARY_SLOTS);
  localparam int PU_W       = $clog2(PRIMARY_SLOTS + 1);
  localparam int SI_W       = $clog2(SUCCESSOR_SLOTS);
  localparam int SU_W       = $clog2(SUCCESSOR_SLOTS + 1);
  localparam int SA_W       = PI_W + SI_W;
  localparam int SMEM_DEPTH = PRIMARY_SLOTS << SI_W;

  // Queue between front and back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // Port field widths
  localparam int BYTE_W   = 8;
  localparam int SYM_W    = 7;
  localparam int SLOT_W   = 5;
  localparam int CNT_W    = 16;
  localparam int STATUS_W = 2;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_LOWER_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [BYTE_W-1:0] CH_UPPER_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

  typedef logic [SYM_W-1:0]      sym_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_ONE = count_t'(1);

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DROP  = 2'd0,
    ST_FIRST = 2'd1,
    ST_PAIR  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Classification made by the front end
  typedef enum logic [1:0] {
    KIND_DROP  = 2'd0,
    KIND_FIRST = 2'd1,
    KIND_PAIR  = 2'd2
  } kind_e;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_PSRCH = 2'd1,
    BK_SSRCH = 2'd2
  } bk_state_e;

  // Classified item
  typedef struct packed {
    kind_e kind;
    sym_t  prev;
    sym_t  sym;
  } item_t;

  // Front end to queue
  typedef struct packed {
    logic  push;
    item_t item;
  } push_t;

  // Queue head to back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  // One result
  typedef struct packed {
    status_e           status;
    sym_t              prev;
    sym_t              next;
    logic [SLOT_W-1:0] pslot;
    logic [SLOT_W-1:0] sslot;
    logic [CNT_W-1:0]  pcount;
    logic [CNT_W-1:0]  tcount;
    logic              new_p;
    logic              new_s;
  } result_t;

  // Saturating increment
  function automatic count_t sat_inc(input count_t v);
    return (&v) ? v : v + COUNT_ONE;
  endfunction

endpackage

### hdl/bft_front.sv
// ----------------------------------------------------------------------------
// bft_front
// Accepts raw bytes, keeps letters and space, folds case and tags each byte
// as dropped, first symbol or pair, tracking the held symbol.
// ----------------------------------------------------------------------------
module bft_front import bft_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              q_full_i,
  output push_t             push_o
);

  logic held_valid_q, held_valid_d;
  sym_t held_q, held_d;
  logic acc;
  logic keep;
  sym_t sym;

  // Symbol filter
  always_comb begin
    keep = 1'b1;
    sym  = '0;
    if (in_byte_i inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      sym = SYM_W'(in_byte_i - CASE_OFFSET);
    end else if ((in_byte_i inside {[CH_UPPER_A:CH_UPPER_Z]}) || in_byte_i == CH_SPACE) begin
      sym = SYM_W'(in_byte_i);
    end else begin
      keep = 1'b0;
    end
  end

  assign acc        = in_valid_i & ~q_full_i;
  assign in_ready_o = ~q_full_i;

  // Classification and held symbol
  always_comb begin
    held_valid_d     = held_valid_q;
    held_d           = held_q;
    push_o.push      = acc;
    push_o.item.sym  = sym;
    push_o.item.prev = '0;
    if (!keep) begin
      push_o.item.kind = KIND_DROP;
    end else if (!held_valid_q) begin
      push_o.item.kind = KIND_FIRST;
    end else begin
      push_o.item.kind = KIND_PAIR;
      push_o.item.prev = held_q;
    end
    if (acc && keep) begin
      held_valid_d = 1'b1;
      held_d       = sym;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_q       <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_q       <= held_d;
    end
  end

endmodule

### hdl/bft_queue.sv
// ----------------------------------------------------------------------------
// bft_queue
// Short FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module bft_queue import bft_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  output logic   full_o,
  output qhead_t head_o,
  input  logic   pop_i
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QP_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QP_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  function automatic logic [QP_W-1:0] ptr_inc(input logic [QP_W-1:0] p);
    return (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : p + QP_W'(1);
  endfunction

  assign full_o       = (cnt_q == QC_W'(QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];
  assign do_push      = push_i.push & ~full_o;
  assign do_pop       = pop_i & head_o.valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + QC_W'(do_push) - QC_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

### hdl/bft_back.sv
// ----------------------------------------------------------------------------
// bft_back
// Searches the first-symbol table and the successor list one entry per
// cycle, updates counts and loads the result register.
// ----------------------------------------------------------------------------
module bft_back import bft_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  qhead_t  head_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  bk_state_e       state_q, state_d;
  item_t           cur_q, cur_d;
  logic [PU_W-1:0] pidx_q, pidx_d;
  logic [PU_W-1:0] pused_q, pused_d;
  logic [SU_W-1:0] sidx_q, sidx_d;
  logic [SU_W-1:0] scnt_q, scnt_d;
  logic            out_valid_q, out_valid_d;
  result_t         res_q, res_d;

  // Table memories
  sym_t            plet_mem  [PRIMARY_SLOTS];
  count_t          ptot_mem  [PRIMARY_SLOTS];
  logic [SU_W-1:0] sused_mem [PRIMARY_SLOTS];
  sym_t            slet_mem  [SMEM_DEPTH];
  count_t          stot_mem  [SMEM_DEPTH];

  sym_t            plet_rd_q, slet_rd_q;
  count_t          ptot_rd_q, stot_rd_q;
  logic [SU_W-1:0] sused_rd_q;

  logic [PI_W-1:0] p_raddr, p_waddr;
  logic [SA_W-1:0] s_raddr, s_waddr;
  logic            plet_we, slet_we, tot_we;
  count_t          ptot_wd, stot_wd;
  logic [SU_W-1:0] sused_wd;

  logic            p_end, p_hit, p_full;
  logic            s_end, s_hit, s_full;
  logic            out_free, start, load;
  result_t         ld_res;

  // Search conditions
  assign p_end    = (pidx_q == pused_q);
  assign p_hit    = (plet_rd_q == cur_q.prev);
  assign p_full   = (pused_q == PU_W'(PRIMARY_SLOTS));
  assign s_end    = (sidx_q == scnt_q);
  assign s_hit    = (slet_rd_q == cur_q.sym);
  assign s_full   = (scnt_q == SU_W'(SUCCESSOR_SLOTS));
  assign out_free = ~out_valid_q | out_ready_i;
  assign start    = (state_q == BK_IDLE) & head_i.valid & out_free;

  // Memory addresses: reads follow the next index so data lines up with it
  assign p_raddr = pidx_d[PI_W-1:0];
  assign s_raddr = {pidx_d[PI_W-1:0], sidx_d[SI_W-1:0]};
  assign p_waddr = pidx_q[PI_W-1:0];
  assign s_waddr = {pidx_q[PI_W-1:0], sidx_q[SI_W-1:0]};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (start && head_i.item.kind == KIND_PAIR) begin
          state_d = BK_PSRCH;
        end
      end
      BK_PSRCH: begin
        if (p_end) begin
          state_d = BK_IDLE;
        end else if (p_hit) begin
          state_d = BK_SSRCH;
        end
      end
      BK_SSRCH: begin
        if (s_end || s_hit) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath, table writes and result load
  always_comb begin
    cur_d    = cur_q;
    pidx_d   = pidx_q;
    pused_d  = pused_q;
    sidx_d   = sidx_q;
    scnt_d   = scnt_q;
    pop_o    = 1'b0;
    load     = 1'b0;
    ld_res   = '0;
    plet_we  = 1'b0;
    slet_we  = 1'b0;
    tot_we   = 1'b0;
    ptot_wd  = COUNT_ONE;
    stot_wd  = COUNT_ONE;
    sused_wd = SU_W'(1);
    case (state_q)
      BK_IDLE: begin
        pidx_d = '0;
        sidx_d = '0;
        if (start) begin
          pop_o = 1'b1;
          cur_d = head_i.item;
          case (head_i.item.kind)
            KIND_DROP: begin
              load          = 1'b1;
              ld_res.status = ST_DROP;
            end
            KIND_FIRST: begin
              load          = 1'b1;
              ld_res.status = ST_FIRST;
              ld_res.next   = head_i.item.sym;
            end
            default: ;
          endcase
        end
      end
      BK_PSRCH: begin
        if (p_end) begin
          load        = 1'b1;
          ld_res.prev = cur_q.prev;
          ld_res.next = cur_q.sym;
          if (p_full) begin
            ld_res.status = ST_FULL;
          end else begin
            // new first symbol with its first successor
            plet_we       = 1'b1;
            slet_we       = 1'b1;
            tot_we        = 1'b1;
            pused_d       = pused_q + PU_W'(1);
            ld_res.status = ST_PAIR;
            ld_res.pslot  = SLOT_W'(pidx_q);
            ld_res.pcount = CNT_W'(COUNT_ONE);
            ld_res.tcount = CNT_W'(COUNT_ONE);
            ld_res.new_p  = 1'b1;
            ld_res.new_s  = 1'b1;
          end
        end else if (p_hit) begin
          scnt_d = sused_rd_q;
          sidx_d = '0;
        end else begin
          pidx_d = pidx_q + PU_W'(1);
        end
      end
      BK_SSRCH: begin
        if (s_end || s_hit) begin
          load         = 1'b1;
          ld_res.prev  = cur_q.prev;
          ld_res.next  = cur_q.sym;
          ld_res.pslot = SLOT_W'(pidx_q);
          if (s_end && s_full) begin
            ld_res.status = ST_FULL;
          end else begin
            tot_we  = 1'b1;
            ptot_wd = sat_inc(ptot_rd_q);
            if (s_end) begin
              // new successor at the end of the list
              slet_we      = 1'b1;
              sused_wd     = scnt_q + SU_W'(1);
              stot_wd      = COUNT_ONE;
              ld_res.new_s = 1'b1;
            end else begin
              sused_wd = scnt_q;
              stot_wd  = sat_inc(stot_rd_q);
            end
            ld_res.status = ST_PAIR;
            ld_res.sslot  = SLOT_W'(sidx_q);
            ld_res.pcount = CNT_W'(stot_wd);
            ld_res.tcount = CNT_W'(ptot_wd);
          end
        end else begin
          sidx_d = sidx_q + SU_W'(1);
        end
      end
      default: ;
    endcase
    // result register
    if (load) begin
      out_valid_d = 1'b1;
      res_d       = ld_res;
    end else begin
      out_valid_d = out_valid_q & ~out_ready_i;
      res_d       = res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      pidx_q      <= '0;
      pused_q     <= '0;
      sidx_q      <= '0;
      scnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pidx_q      <= pidx_d;
      pused_q     <= pused_d;
      sidx_q      <= sidx_d;
      scnt_q      <= scnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
  end

  // First-symbol table
  always_ff @(posedge clk_i) begin
    if (plet_we) begin
      plet_mem[p_waddr] <= cur_q.prev;
    end
    if (tot_we) begin
      ptot_mem[p_waddr]  <= ptot_wd;
      sused_mem[p_waddr] <= sused_wd;
    end
    plet_rd_q  <= plet_mem[p_raddr];
    ptot_rd_q  <= ptot_mem[p_raddr];
    sused_rd_q <= sused_mem[p_raddr];
  end

  // Successor lists
  always_ff @(posedge clk_i) begin
    if (slet_we) begin
      slet_mem[s_waddr] <= cur_q.sym;
    end
    if (tot_we) begin
      stot_mem[s_waddr] <= stot_wd;
    end
    slet_rd_q <= slet_mem[s_raddr];
    stot_rd_q <= stot_mem[s_raddr];
  end

endmodule

### hdl/bigram_frequency_table.sv
// ----------------------------------------------------------------------------
// bigram_frequency_table
// Counts pairs of consecutive letters/spaces in a byte stream, keeping a
// first-seen table of first symbols, each with a first-seen successor list.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------
//   in      | input     | in_valid_i / in_ready_o  | in_byte_i
//   out     | output    | out_valid_o / out_ready_i| status_o .. new_successor_o
//
// Dropped and first-symbol bytes load their result straight from the idle
// state. A pair is searched for in the first-symbol table and then in that
// symbol's successor list, one table-memory read per cycle. Reset clears
// the used counts and control only; table contents need no clearing. A
// two-entry queue lets the input side keep taking bytes while the back end
// searches or the output stalls.
// ----------------------------------------------------------------------------
module bigram_frequency_table import bft_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [BYTE_W-1:0]   in_byte_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SYM_W-1:0]    prev_symbol_o,
  output logic [SYM_W-1:0]    next_symbol_o,
  output logic [SLOT_W-1:0]   primary_slot_o,
  output logic [SLOT_W-1:0]   successor_slot_o,
  output logic [CNT_W-1:0]    pair_count_o,
  output logic [CNT_W-1:0]    primary_count_o,
  output logic                new_primary_o,
  output logic                new_successor_o
);

  push_t   push;
  qhead_t  head;
  logic    q_full;
  logic    pop;
  result_t res;

  bft_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_byte_i  (in_byte_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  bft_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  bft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  // Result fields to ports
  assign status_o         = res.status;
  assign prev_symbol_o    = res.prev;
  assign next_symbol_o    = res.next;
  assign primary_slot_o   = res.pslot;
  assign successor_slot_o = res.sslot;
  assign pair_count_o     = res.pcount;
  assign primary_count_o  = res.tcount;
  assign new_primary_o    = res.new_p;
  assign new_successor_o  = res.new_s;

endmodule

### hdl/bft_checker.sv
// ----------------------------------------------------------------------------
// bft_checker
// Port-level checks on the result stream of the bigram frequency table.
// ----------------------------------------------------------------------------
module bft_checker import bft_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_o,
  input logic [SYM_W-1:0]    prev_symbol_o,
  input logic [SYM_W-1:0]    next_symbol_o,
  input logic [CNT_W-1:0]    pair_count_o,
  input logic [CNT_W-1:0]    primary_count_o,
  input logic                new_primary_o,
  input logic                new_successor_o
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(pair_count_o) && $stable(next_symbol_o))
    else $error("stalled result changed");

  // A dropped byte carries no symbols
  a_drop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DROP |->
      prev_symbol_o == '0 && next_symbol_o == '0 && pair_count_o == '0)
    else $error("dropped byte with nonzero fields");

  // A counted pair has nonzero counts, first-symbol count not below pair count
  a_pair_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_PAIR |->
      pair_count_o != '0 && primary_count_o >= pair_count_o && prev_symbol_o != '0)
    else $error("pair counts inconsistent");

  // A new first symbol always brings a new successor with counts of one
  a_new_primary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_primary_o |->
      new_successor_o && pair_count_o == CNT_W'(1) && primary_count_o == CNT_W'(1))
    else $error("new first symbol without fresh counts");

endmodule

bind bigram_frequency_table bft_checker u_bft_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .prev_symbol_o   (prev_symbol_o),
  .next_symbol_o   (next_symbol_o),
  .pair_count_o    (pair_count_o),
  .primary_count_o (primary_count_o),
  .new_primary_o   (new_primary_o),
  .new_successor_o (new_successor_o)
);
